// ----- hdl/cch_pkg.sv -----
// cch_pkg: shared types, codes and constants of the channel-change requester
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package cch_pkg;

	// link bytes
	localparam logic [7:0] BYTE_REQUEST = 8'h85;
	localparam logic [7:0] BYTE_ESCAPE  = 8'h10;
	localparam logic [7:0] BYTE_ACK     = 8'h06;
	localparam logic [7:0] BYTE_CONFIRM = 8'hE4;

	// register reset values
	localparam logic [15:0] CHANNEL_MIN_RST = 16'd1;
	localparam logic [15:0] CHANNEL_MAX_RST = 16'hFFFF;
	localparam logic [15:0] REPLY_TICKS_RST = 16'd2000;

	// result queue geometry
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_BYTE   = 2'd1,
		CMD_TICK   = 2'd2,
		CMD_TXFAIL = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_CHANNEL_MIN = 2'd0,
		REG_CHANNEL_MAX = 2'd1,
		REG_REPLY_TICKS = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_OK        = 3'd1,
		ST_BAD_CHAN  = 3'd2,
		ST_ASK_FAIL  = 3'd3,
		ST_NO_ACK    = 3'd4,
		ST_SEND_FAIL = 3'd5,
		ST_NO_CONF   = 3'd6,
		ST_RSVD      = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_ESCAPE  = 4'b0010,
		PH_ACK     = 4'b0100,
		PH_CONFIRM = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] channel;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        done_res;
		logic [2:0]  status;
		logic        last;
	} result_t;

	// words pushed into the result queue for one processed item
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	typedef struct packed {
		logic [15:0] channel_min;
		logic [15:0] channel_max;
		logic [15:0] reply_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/cch_if.sv -----
// cch_if: valid/ready channel interfaces for items, results and register writes
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

interface cch_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [15:0] channel;
	logic [7:0]  rx_byte;

	modport source (output valid, output cmd, output channel, output rx_byte, input ready);
	modport sink   (input valid, input cmd, input channel, input rx_byte, output ready);
endinterface

interface cch_result_if;
	logic        valid;
	logic        ready;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        done_res;
	logic [2:0]  status;
	logic        last;

	modport source (output valid, output tx_valid, output tx_byte, output done_res,
		output status, output last, input ready);
	modport sink   (input valid, input tx_valid, input tx_byte, input done_res,
		input status, input last, output ready);
endinterface

interface cch_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/channel_change_handshake_core.sv -----
// channel_change_handshake_core: requester side of the channel-change exchange
// depends on cch_pkg, cch_if, cch_ctrl and cch_outq
`timescale 1ns / 1ps
`default_nettype none

// channel   modport  word
// item      sink     cmd, channel, rx_byte
// result    source   tx_valid, tx_byte, done_res, status, last
// cfg       sink     index, data (channel_min, channel_max, reply_ticks)
//
// one item per cycle while the result queue has room; an item passes the input register, then the result queue
// an acknowledge that sends both channel bytes pushes two words at once
// items wait in the input register while the four-word result queue lacks room for two words
// reset clears exchange state, registers and queue pointers; no clearing pass

module channel_change_handshake_core
	import cch_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	cch_item_if.sink   item,
	cch_result_if.source result,
	cch_cfg_if.sink    cfg
);

	cfg_t    cfg_q;
	item_t   in_item;
	push_t   push;
	logic    space_ok;
	logic    item_ready;
	result_t out_word;
	logic    out_valid;

	// register writes are always taken; unknown index is dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_min <= CHANNEL_MIN_RST;
			cfg_q.channel_max <= CHANNEL_MAX_RST;
			cfg_q.reply_ticks <= REPLY_TICKS_RST;
		end else if (cfg.valid) begin
			case (reg_idx_t'(cfg.index))
				REG_CHANNEL_MIN: cfg_q.channel_min <= cfg.data;
				REG_CHANNEL_MAX: cfg_q.channel_max <= cfg.data;
				REG_REPLY_TICKS: cfg_q.reply_ticks <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// pack the incoming word
	assign in_item.cmd     = item.cmd;
	assign in_item.channel = item.channel;
	assign in_item.rx_byte = item.rx_byte;
	assign item.ready      = item_ready;

	// decode the word and step the exchange
	cch_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item_ready),
		.in_item  (in_item),
		.cfg      (cfg_q),
		.space_ok (space_ok),
		.push     (push)
	);

	// hold results until the link side takes them
	cch_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.out_valid (out_valid),
		.out_ready (result.ready),
		.out_word  (out_word)
	);

	assign result.valid    = out_valid;
	assign result.tx_valid = out_word.tx_valid;
	assign result.tx_byte  = out_word.tx_byte;
	assign result.done_res = out_word.done_res;
	assign result.status   = out_word.status;
	assign result.last     = out_word.last;

endmodule

`default_nettype wire

// ----- hdl/cch_ctrl.sv -----
// cch_ctrl: input register, exchange state and result generation
// depends on cch_pkg
`timescale 1ns / 1ps
`default_nettype none

module cch_ctrl
	import cch_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	input  wire item_t in_item,
	input  wire cfg_t  cfg,
	input  wire logic  space_ok,
	output push_t      push
);

	logic        valid_s1;
	item_t       item_s1;
	logic        take;

	phase_t      phase_q, phase_n;
	logic [15:0] timer_q, timer_n;
	logic [15:0] latch_q, latch_n;
	logic [15:0] tick_inc;
	push_t       push_n;

	assign take     = valid_s1 && space_ok;
	assign in_ready = !valid_s1 || take;
	assign tick_inc = timer_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	function automatic result_t done_word(input status_t st);
		result_t r;
		r          = '0;
		r.done_res = 1'b1;
		r.status   = st;
		r.last     = 1'b1;
		return r;
	endfunction

	function automatic result_t tx_word(input logic [7:0] b, input logic lst);
		result_t r;
		r          = '0;
		r.tx_valid = 1'b1;
		r.tx_byte  = b;
		r.last     = lst;
		return r;
	endfunction

	always_comb begin
		phase_n = phase_q;
		timer_n = timer_q;
		latch_n = latch_q;
		push_n  = '0;
		case (cmd_t'(item_s1.cmd))
			CMD_START: begin
				timer_n = '0;
				if (item_s1.channel < cfg.channel_min || item_s1.channel > cfg.channel_max) begin
					phase_n      = PH_IDLE;
					push_n.count = 2'd1;
					push_n.r0    = done_word(ST_BAD_CHAN);
				end else begin
					latch_n      = item_s1.channel;
					phase_n      = PH_ESCAPE;
					push_n.count = 2'd1;
					push_n.r0    = tx_word(BYTE_REQUEST, 1'b1);
				end
			end
			CMD_BYTE: begin
				case (phase_q)
					PH_ESCAPE: begin
						if (item_s1.rx_byte != BYTE_ESCAPE) begin
							phase_n      = PH_IDLE;
							timer_n      = '0;
							push_n.count = 2'd1;
							push_n.r0    = done_word(ST_NO_ACK);
						end else begin
							phase_n = PH_ACK;
							timer_n = '0;
						end
					end
					PH_ACK: begin
						timer_n = '0;
						if (item_s1.rx_byte != BYTE_ACK) begin
							phase_n      = PH_IDLE;
							push_n.count = 2'd1;
							push_n.r0    = done_word(ST_NO_ACK);
						end else begin
							phase_n      = PH_CONFIRM;
							push_n.count = 2'd2;
							push_n.r0    = tx_word(latch_q[7:0], 1'b0);
							push_n.r1    = tx_word(latch_q[15:8], 1'b1);
						end
					end
					PH_CONFIRM: begin
						phase_n      = PH_IDLE;
						timer_n      = '0;
						push_n.count = 2'd1;
						push_n.r0    = done_word((item_s1.rx_byte == BYTE_CONFIRM) ?
							ST_OK : ST_NO_CONF);
					end
					default: begin
					end
				endcase
			end
			CMD_TICK: begin
				if (phase_q != PH_IDLE) begin
					if (tick_inc >= cfg.reply_ticks) begin
						phase_n      = PH_IDLE;
						timer_n      = '0;
						push_n.count = 2'd1;
						push_n.r0    = done_word((phase_q == PH_CONFIRM) ?
							ST_NO_CONF : ST_NO_ACK);
					end else begin
						timer_n = tick_inc;
					end
				end
			end
			CMD_TXFAIL: begin
				if (phase_q != PH_IDLE) begin
					phase_n      = PH_IDLE;
					timer_n      = '0;
					push_n.count = 2'd1;
					push_n.r0    = done_word((phase_q == PH_CONFIRM) ?
						ST_SEND_FAIL : ST_ASK_FAIL);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			timer_q <= '0;
			latch_q <= '0;
		end else if (take) begin
			phase_q <= phase_n;
			timer_q <= timer_n;
			latch_q <= latch_n;
		end
	end

	always_comb begin
		push = push_n;
		if (!take) begin
			push.count = 2'd0;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/cch_outq.sv -----
// cch_outq: small result queue, up to two words in per cycle, one word out
// depends on cch_pkg
`timescale 1ns / 1ps
`default_nettype none

module cch_outq
	import cch_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	output logic       space_ok,
	output logic       out_valid,
	input  wire logic  out_ready,
	output result_t    out_word
);

	result_t           slot_q [OQ_DEPTH];
	logic [OQ_AW-1:0]  wr_ptr_q;
	logic [OQ_AW-1:0]  rd_ptr_q;
	logic [OQ_CW-1:0]  count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign out_word  = slot_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	// room for the largest burst of one item
	assign space_ok  = (count_q <= OQ_CW'(OQ_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			slot_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			slot_q[OQ_AW'(wr_ptr_q + OQ_AW'(1))] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= OQ_AW'(wr_ptr_q + OQ_AW'(push.count));
			if (pop) begin
				rd_ptr_q <= OQ_AW'(rd_ptr_q + OQ_AW'(1));
			end
			count_q <= OQ_CW'(count_q + OQ_CW'(push.count) - OQ_CW'(pop));
		end
	end

endmodule

`default_nettype wire

// ----- tb/channel_change_handshake_core_tb.sv -----
// channel_change_handshake_core_tb: self-checking bench for the channel-change requester
// drives items and register writes, predicts every result word and checks it in order
// depends on cch_pkg, cch_if and channel_change_handshake_core
`timescale 1ns / 1ps

module channel_change_handshake_core_tb;
	import cch_pkg::*;

	// run control
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int          SETTLE_CYCLES = 8;    // an item's words pass the input register and the result queue
	localparam int          HOLD_CYCLES   = 300;  // long receiver hold-off
	localparam int          REPORT_CAP    = 200;  // keep the log short if things go badly
	localparam int          PHASE_ITEMS   = 220;  // counted items per random setting

	logic clk;
	logic arst_n;

	cch_item_if   item_bus ();
	cch_result_if result_bus ();
	cch_cfg_if    cfg_bus ();

	channel_change_handshake_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	// predictor state: registers plus the exchange itself
	logic [15:0] lim_min;
	logic [15:0] lim_max;
	logic [15:0] reply_limit;
	phase_t      link_phase;
	logic [15:0] wait_ticks;
	logic [15:0] chan_latch;

	result_t     pending_words[$];  // words the block still owes us, oldest first
	int          errors;
	int          counted_items;     // items that did something (ignored ones excluded)
	bit          idle_on;           // random gaps on both sides when set
	bit          hold_req;          // ask the receiver for one long hold-off
	bit          hold_active;
	int unsigned cycle_count = 0;

	// clock and cycle counter
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog: a correct run finishes far below this
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("channel_change_handshake_core_tb: done, errors");
		$finish;
	end

	// gap length: mostly none, some short, a few long
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------------------------------------------------------- predictor

	function automatic void owe_word(logic tv, logic [7:0] tb, logic dn, status_t st, logic lst);
		pending_words.push_back({tv, tb, dn, st, lst});
	endfunction

	// the exchange ends: back to idle, one status word
	function automatic void close_exchange(status_t st);
		link_phase = PH_IDLE;
		wait_ticks = '0;
		owe_word(1'b0, 8'h00, 1'b1, st, 1'b1);
	endfunction

	// one accepted item: advance the exchange and queue the words it causes
	function automatic void step_exchange(cmd_t c, logic [15:0] ch, logic [7:0] rx);
		if (c == CMD_START) begin
			// a start always drops whatever was running
			link_phase = PH_IDLE;
			wait_ticks = '0;
			if (ch < lim_min || ch > lim_max) begin
				close_exchange(ST_BAD_CHAN);
			end else begin
				chan_latch = ch;
				link_phase = PH_ESCAPE;
				owe_word(1'b1, BYTE_REQUEST, 1'b0, ST_NONE, 1'b1);
			end
			return;
		end
		// anything but a start is ignored while idle
		if (link_phase == PH_IDLE)
			return;
		case (c)
			CMD_BYTE: begin
				case (link_phase)
					PH_ESCAPE: begin
						if (rx != BYTE_ESCAPE) begin
							close_exchange(ST_NO_ACK);
						end else begin
							link_phase = PH_ACK;
							wait_ticks = '0;
						end
					end
					PH_ACK: begin
						if (rx != BYTE_ACK) begin
							close_exchange(ST_NO_ACK);
						end else begin
							// channel goes out low byte first
							link_phase = PH_CONFIRM;
							wait_ticks = '0;
							owe_word(1'b1, chan_latch[7:0], 1'b0, ST_NONE, 1'b0);
							owe_word(1'b1, chan_latch[15:8], 1'b0, ST_NONE, 1'b1);
						end
					end
					default: begin
						close_exchange((rx == BYTE_CONFIRM) ? ST_OK : ST_NO_CONF);
					end
				endcase
			end
			CMD_TICK: begin
				// 16-bit timer; a limit of zero trips on the first tick
				wait_ticks = wait_ticks + 16'd1;
				if (wait_ticks >= reply_limit)
					close_exchange((link_phase == PH_CONFIRM) ? ST_NO_CONF : ST_NO_ACK);
			end
			default: begin
				// the failed send is the request unless the channel bytes went out
				close_exchange((link_phase == PH_CONFIRM) ? ST_SEND_FAIL : ST_ASK_FAIL);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- checker

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			if (errors <= REPORT_CAP)
				$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_word
		result_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= REPORT_CAP)
					$error("extra word: tx_valid %0b tx_byte %0h done_res %0b",
						result_bus.tx_valid, result_bus.tx_byte, result_bus.done_res);
			end else begin
				want = pending_words.pop_front();
				compare_field("tx_valid", want.tx_valid, result_bus.tx_valid);
				compare_field("tx_byte", want.tx_byte, result_bus.tx_byte);
				compare_field("done_res", want.done_res, result_bus.done_res);
				compare_field("status", want.status, result_bus.status);
				compare_field("last", want.last, result_bus.last);
			end
		end
	end

	// ---------------------------------------------------------------- receiver

	// ready changes at the falling edge; a hold-off is counted here, not by the sender
	initial begin
		int n;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_active = 1'b1;
				result_bus.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_active = 1'b0;
				result_bus.ready = 1'b1;
			end else begin
				n = pick_gap();
				result_bus.ready = (n == 0);
				if (n > 1)
					repeat (n - 1) @(negedge clk);
			end
		end
	end

	// ---------------------------------------------------------------- sender

	// offer one item; returns at the rising edge that takes it
	// valid stays high, so the next call or park must follow at the next falling edge
	task automatic send_word(cmd_t c, logic [15:0] ch, logic [7:0] rx);
		int gap;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			item_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_bus.valid   = 1'b1;
		item_bus.cmd     = c;
		item_bus.channel = ch;
		item_bus.rx_byte = rx;
		do
			@(posedge clk);
		while (!item_bus.ready);
		if (c == CMD_START || link_phase != PH_IDLE)
			counted_items++;
		step_exchange(c, ch, rx);
	endtask

	// unused fields carry random values so every bit toggles
	task automatic send_start(logic [15:0] ch);
		send_word(CMD_START, ch, 8'($urandom));
	endtask

	task automatic send_rx(logic [7:0] b);
		send_word(CMD_BYTE, 16'($urandom), b);
	endtask

	task automatic send_tick();
		send_word(CMD_TICK, 16'($urandom), 8'($urandom));
	endtask

	task automatic send_txfail();
		send_word(CMD_TXFAIL, 16'($urandom), 8'($urandom));
	endtask

	task automatic park();
		@(negedge clk);
		item_bus.valid = 1'b0;
	endtask

	// stop offering until every owed word has arrived, then let the pipeline empty
	task automatic settle();
		park();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write, only with the block quiet
	task automatic write_reg(reg_idx_t idx, logic [15:0] v);
		settle();
		cfg_bus.valid = 1'b1;
		cfg_bus.index = idx;
		cfg_bus.data  = v;
		do
			@(posedge clk);
		while (!cfg_bus.ready);
		case (idx)
			REG_CHANNEL_MIN: lim_min = v;
			REG_CHANNEL_MAX: lim_max = v;
			REG_REPLY_TICKS: reply_limit = v;
			default: ;
		endcase
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// ---------------------------------------------------------------- directed tests

	// reset limits: channel 0 is below the reset minimum, 65535 is the reset maximum
	task automatic test_reset_limits();
		send_start(16'h0000);
		send_start(16'hFFFF);
		repeat (3) send_tick();
		send_rx(BYTE_ESCAPE);
		send_rx(BYTE_ACK);
		send_rx(BYTE_CONFIRM);
	endtask

	// bytes, ticks and transmit failures with no exchange running do nothing
	task automatic test_idle_commands();
		send_tick();
		send_rx(BYTE_ESCAPE);
		send_txfail();
		send_rx(8'hFF);
	endtask

	// wrong reply byte in each waiting phase
	task automatic test_reply_errors();
		send_start(16'h1234);
		send_rx(8'h00);
		send_start(16'hA55A);
		send_rx(BYTE_ESCAPE);
		send_rx(BYTE_CONFIRM);
		send_start(16'h00FF);
		send_rx(BYTE_ESCAPE);
		send_rx(BYTE_ACK);
		send_rx(BYTE_ACK);
	endtask

	// transmit failure maps to ask failed before the channel bytes, send failed after
	task automatic test_transmit_failures();
		send_start(16'h0001);
		send_txfail();
		send_start(16'h5A5A);
		send_rx(BYTE_ESCAPE);
		send_txfail();
		send_start(16'hC3A5);
		send_rx(BYTE_ESCAPE);
		send_rx(BYTE_ACK);
		send_txfail();
	endtask

	// start while busy drops the running exchange and begins a new one
	task automatic test_restart();
		send_start(16'h0101);
		send_rx(BYTE_ESCAPE);
		send_start(16'h0202);
		send_rx(BYTE_ESCAPE);
		send_rx(BYTE_ACK);
		send_start(16'hFF00);
		send_start(16'h0000);   // refused: the new exchange never starts
		send_rx(BYTE_ESCAPE);   // ignored, block is idle
	endtask

	// reply timeout per phase; the timer restarts for each awaited byte
	task automatic test_timeouts();
		write_reg(REG_REPLY_TICKS, 16'd1);
		send_start(16'h0010);
		send_tick();
		send_start(16'h0020);
		send_rx(BYTE_ESCAPE);
		send_tick();
		send_start(16'h0030);
		send_rx(BYTE_ESCAPE);
		send_rx(BYTE_ACK);
		send_tick();
		write_reg(REG_REPLY_TICKS, 16'd0);
		send_start(16'h0040);
		send_tick();
		write_reg(REG_REPLY_TICKS, 16'd3);
		send_start(16'h0050);
		repeat (2) send_tick();
		send_rx(BYTE_ESCAPE);
		repeat (2) send_tick();
		send_rx(BYTE_ACK);
		repeat (3) send_tick();
	endtask

	// limit extremes, an empty window, and a write to the unused index
	task automatic test_limit_window();
		write_reg(REG_CHANNEL_MIN, 16'h0000);
		write_reg(REG_CHANNEL_MAX, 16'h0000);
		send_start(16'h0000);
		send_txfail();
		send_start(16'h0001);
		write_reg(REG_CHANNEL_MIN, 16'h8000);
		write_reg(REG_CHANNEL_MAX, 16'h7FFF);
		send_start(16'h8000);
		send_start(16'h7FFF);
		write_reg(REG_NONE, 16'hFFFF);
		write_reg(REG_CHANNEL_MIN, 16'hFFFF);
		write_reg(REG_CHANNEL_MAX, 16'hFFFF);
		send_start(16'hFFFE);
		send_start(16'hFFFF);
		send_txfail();
		write_reg(REG_CHANNEL_MIN, 16'h0000);
		write_reg(REG_CHANNEL_MAX, 16'hFFFF);
		write_reg(REG_REPLY_TICKS, 16'hFFFF);
		send_start(16'h0000);
		send_txfail();
	endtask

	// receiver holds off for a long stretch while full exchanges keep coming:
	// the result queue fills and the input stalls
	task automatic test_result_backpressure();
		park();
		hold_req = 1'b1;
		wait (hold_active);
		idle_on = 1'b0;
		for (int i = 0; i < 6; i++) begin
			send_start(16'($urandom));
			send_rx(BYTE_ESCAPE);
			send_rx(BYTE_ACK);
			send_rx(BYTE_CONFIRM);
		end
		settle();
		idle_on = 1'b1;
	endtask

	// ---------------------------------------------------------------- random tests

	// one exchange: mostly the right replies, with the odd fault, restart or stray item
	task automatic run_exchange();
		logic [15:0] ch;
		logic [7:0]  want;
		int          dice;
		if (lim_min <= lim_max && $urandom_range(0, 99) < 85)
			ch = 16'($urandom_range(lim_max, lim_min));
		else
			ch = 16'($urandom);
		send_start(ch);
		while (link_phase != PH_IDLE) begin
			dice = $urandom_range(0, 99);
			want = (link_phase == PH_ESCAPE) ? BYTE_ESCAPE :
				(link_phase == PH_ACK) ? BYTE_ACK : BYTE_CONFIRM;
			if (dice < 78) begin
				// a few ticks short of the timeout, then the right byte
				while ($urandom_range(0, 2) == 0 && int'(wait_ticks) + 1 < int'(reply_limit))
					send_tick();
				send_rx(want);
			end else if (dice < 84) begin
				send_rx(want ^ 8'($urandom_range(1, 255)));
			end else if (dice < 89) begin
				send_txfail();
			end else if (dice < 94) begin
				// only run out the clock when the limit is short
				if (reply_limit <= 16'd64) begin
					while (link_phase != PH_IDLE)
						send_tick();
				end else begin
					send_txfail();
				end
			end else if (dice < 97) begin
				send_start(16'($urandom));
			end else begin
				send_word(cmd_t'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
			end
		end
	endtask

	task automatic random_phase(logic [15:0] lo, logic [15:0] hi, logic [15:0] ticks, bit gaps);
		int first;
		write_reg(REG_CHANNEL_MIN, lo);
		write_reg(REG_CHANNEL_MAX, hi);
		write_reg(REG_REPLY_TICKS, ticks);
		idle_on = gaps;
		first = counted_items;
		while (counted_items - first < PHASE_ITEMS) begin
			// stray items between exchanges are ignored by an idle block
			if ($urandom_range(0, 9) == 0)
				send_word(cmd_t'($urandom_range(1, 3)), 16'($urandom), 8'($urandom));
			run_exchange();
			// now and then the sender waits for every owed word
			if ($urandom_range(0, 19) == 0)
				settle();
		end
		idle_on = 1'b1;
	endtask

	task automatic test_random_exchanges();
		logic [15:0] a;
		logic [15:0] b;
		random_phase(16'd1, 16'hFFFF, 16'd4, 1'b1);
		random_phase(16'd0, 16'hFFFF, 16'd1, 1'b0);
		a = 16'($urandom);
		b = 16'($urandom);
		random_phase((a < b) ? a : b, (a < b) ? b : a, 16'($urandom_range(2, 12)), 1'b1);
		random_phase(16'd0, 16'd0, 16'd0, 1'b1);
		random_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
		// raw pair: an inverted window refuses every start
		random_phase(16'($urandom), 16'($urandom), 16'($urandom_range(1, 16)), 1'b1);
	endtask

	// ---------------------------------------------------------------- main sequence

	initial begin
		// every input known from time zero
		arst_n           = 1'b0;
		item_bus.valid   = 1'b0;
		item_bus.cmd     = CMD_START;
		item_bus.channel = '0;
		item_bus.rx_byte = '0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.index    = REG_CHANNEL_MIN;
		cfg_bus.data     = '0;
		result_bus.ready = 1'b0;
		errors           = 0;
		counted_items    = 0;
		idle_on          = 1'b1;
		hold_req         = 1'b0;
		hold_active      = 1'b0;

		// predictor after reset
		lim_min     = CHANNEL_MIN_RST;
		lim_max     = CHANNEL_MAX_RST;
		reply_limit = REPLY_TICKS_RST;
		link_phase  = PH_IDLE;
		wait_ticks  = '0;
		chan_latch  = '0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_limits();
		test_idle_commands();
		test_reply_errors();
		test_transmit_failures();
		test_restart();
		test_timeouts();
		test_limit_window();
		test_result_backpressure();
		test_random_exchanges();

		settle();
		if (errors == 0 && pending_words.size() == 0) begin
			$display("channel_change_handshake_core_tb: done, clean");
		end else begin
			$display("channel_change_handshake_core_tb: done, errors");
		end
		$finish;
	end

endmodule
